### src/xmse_pkg.sv
package xmse_pkg;

    localparam int MaxBytes = 7;
    localparam int LenW = $clog2(MaxBytes + 1);
    localparam int IdxW = $clog2(MaxBytes);
    localparam int QDepth = 2;
    localparam int QPtrW = $clog2(QDepth);
    localparam int QCntW = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        FUNC_REG_REG = 2'd0,
        FUNC_REG_IMM = 2'd1,
        FUNC_REG_MEM = 2'd2,
        FUNC_MEM_REG = 2'd3
    } func_t;

    localparam logic [2:0] RegEsp = 3'd4;
    localparam logic [2:0] RegEbp = 3'd5;
    localparam logic [2:0] RmSib = 3'd4;
    localparam logic [2:0] RmDisp32 = 3'd5;
    localparam logic [7:0] SibEspBase = 8'h24;

    localparam logic [1:0] ModNoDisp = 2'd0;
    localparam logic [1:0] ModDisp8 = 2'd1;
    localparam logic [1:0] ModDisp32 = 2'd2;
    localparam logic [1:0] ModReg = 2'd3;

    typedef struct packed {
        logic [MaxBytes-1:0][7:0] bytes;
        logic [LenW-1:0]          len;
    } enc_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

### src/xmse_front.sv
module xmse_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          func,
    input  logic [7:0]          opcode,
    input  logic [2:0]          reg_field,
    input  logic [2:0]          rm_field,
    input  logic                has_base,
    input  logic                has_index,
    input  logic [2:0]          index_field,
    input  logic [3:0]          scale,
    input  logic signed [31:0]  disp,
    input  logic [7:0]          imm,
    input  xmse_pkg::q_status_t q_status,
    output logic                q_push,
    output xmse_pkg::enc_t      q_data
);

    xmse_pkg::enc_t enc;
    xmse_pkg::enc_t hold_reg;
    logic           hold_valid_reg;
    logic           hold_valid_next;
    logic [1:0]     sc;
    logic [1:0]     mod;
    logic [2:0]     disp_bytes;
    logic           have_sib;
    logic           fits8;
    logic [7:0]     modrm;
    logic [7:0]     sib;
    logic [2:0]     sib_base;

    always_comb
    begin
        unique case (scale)
            4'd2:    sc = 2'd1;
            4'd4:    sc = 2'd2;
            4'd8:    sc = 2'd3;
            default: sc = 2'd0;
        endcase
    end

    always_comb
    begin
        fits8 = (disp[31:7] == '0) || (disp[31:7] == '1);
        if (!has_base)
        begin
            mod        = xmse_pkg::ModNoDisp;
            disp_bytes = 3'd4;
        end
        else if (disp == '0 && rm_field != xmse_pkg::RegEbp)
        begin
            mod        = xmse_pkg::ModNoDisp;
            disp_bytes = 3'd0;
        end
        else if (fits8)
        begin
            mod        = xmse_pkg::ModDisp8;
            disp_bytes = 3'd1;
        end
        else
        begin
            mod        = xmse_pkg::ModDisp32;
            disp_bytes = 3'd4;
        end

        sib_base = has_base ? rm_field : xmse_pkg::RegEbp;
        if (has_index)
        begin
            have_sib = 1'b1;
            modrm    = {mod, reg_field, xmse_pkg::RmSib};
            sib      = {sc, index_field, sib_base};
        end
        else if (!has_base)
        begin
            have_sib = 1'b0;
            modrm    = {xmse_pkg::ModNoDisp, reg_field, xmse_pkg::RmDisp32};
            sib      = '0;
        end
        else if (rm_field == xmse_pkg::RegEsp)
        begin
            have_sib = 1'b1;
            modrm    = {mod, reg_field, xmse_pkg::RmSib};
            sib      = xmse_pkg::SibEspBase;
        end
        else
        begin
            have_sib = 1'b0;
            modrm    = {mod, reg_field, rm_field};
            sib      = '0;
        end
    end

    always_comb
    begin
        enc = '0;
        unique case (func)
            xmse_pkg::FUNC_REG_REG:
            begin
                enc.bytes[0] = opcode;
                enc.bytes[1] = {xmse_pkg::ModReg, reg_field, rm_field};
                enc.len      = xmse_pkg::LenW'(2);
            end
            xmse_pkg::FUNC_REG_IMM:
            begin
                enc.bytes[0] = opcode + {5'd0, reg_field};
                enc.bytes[1] = imm;
                enc.len      = xmse_pkg::LenW'(2);
            end
            default:
            begin
                enc.bytes[0] = opcode;
                enc.bytes[1] = modrm;
                if (have_sib)
                begin
                    enc.bytes[6:2] = {disp[31:24], disp[23:16], disp[15:8], disp[7:0], sib};
                end
                else
                begin
                    enc.bytes[5:2] = {disp[31:24], disp[23:16], disp[15:8], disp[7:0]};
                end
                enc.len = xmse_pkg::LenW'(2) + xmse_pkg::LenW'(have_sib)
                        + xmse_pkg::LenW'(disp_bytes);
            end
        endcase
    end

    assign q_push   = hold_valid_reg && !q_status.full;
    assign q_data   = hold_reg;
    assign in_stall = hold_valid_reg && q_status.full;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
        if (in_valid && !in_stall)
        begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            hold_reg <= enc;
        end
    end

endmodule

### src/xmse_queue.sv
module xmse_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  xmse_pkg::enc_t      push_data,
    input  logic                pop,
    output xmse_pkg::enc_t      pop_data,
    output xmse_pkg::q_status_t status
);

    xmse_pkg::enc_t                 mem [xmse_pkg::QDepth];
    logic [xmse_pkg::QPtrW-1:0]     head_reg;
    logic [xmse_pkg::QPtrW-1:0]     head_next;
    logic [xmse_pkg::QCntW-1:0]     count_reg;
    logic [xmse_pkg::QCntW-1:0]     count_next;
    logic [xmse_pkg::QPtrW-1:0]     wr_ptr;
    logic                           do_push;
    logic                           do_pop;

    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == xmse_pkg::QCntW'(xmse_pkg::QDepth));
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign wr_ptr           = head_reg + count_reg[xmse_pkg::QPtrW-1:0];
    assign pop_data         = mem[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (do_pop)
        begin
            head_next = head_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr] <= push_data;
        end
    end

endmodule

### src/xmse_back.sv
module xmse_back (
    input  logic                clk,
    input  logic                rst_n,
    input  xmse_pkg::q_status_t q_status,
    input  xmse_pkg::enc_t      q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          code_byte,
    output logic                last
);

    xmse_pkg::enc_t             cur_reg;
    logic                       cur_valid_reg;
    logic                       cur_valid_next;
    logic [xmse_pkg::IdxW-1:0]  idx_reg;
    logic [xmse_pkg::IdxW-1:0]  idx_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [7:0]                 code_byte_reg;
    logic                       last_reg;
    logic                       load_out;
    logic                       emit;
    logic                       at_end;

    assign load_out  = !out_valid_reg || !out_stall;
    assign emit      = load_out && cur_valid_reg;
    assign at_end    = (xmse_pkg::LenW'(idx_reg) == cur_reg.len - 1'b1);
    assign q_pop     = q_status.not_empty && (!cur_valid_reg || (emit && at_end));
    assign out_valid = out_valid_reg;
    assign code_byte = code_byte_reg;
    assign last      = last_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = cur_valid_reg;
        end
        if (emit)
        begin
            if (at_end)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (q_pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (emit)
        begin
            code_byte_reg <= cur_reg.bytes[idx_reg];
            last_reg      <= at_end;
        end
    end

endmodule

### src/x86_modrm_sib_encoder.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | func opcode reg_field rm_field has_base
//         |           |                     | has_index index_field scale disp imm
// out     | output    | out_valid/out_stall | code_byte last
//
// One instruction gives 2 to 7 byte transfers, one per cycle while out_stall
// is low and bytes are pending; the byte serializer in the back end sets the rate.
// First byte path: front holding register, queue entry, cur_reg, code_byte_reg.
// Reset clears the front hold valid flag, queue head and count, and serializer state.
// A two-entry queue sits between classify and serialize; an output stall
// backs up the serializer first, then the queue, then in_stall.
module x86_modrm_sib_encoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [7:0]         opcode,
    input  logic [2:0]         reg_field,
    input  logic [2:0]         rm_field,
    input  logic               has_base,
    input  logic               has_index,
    input  logic [2:0]         index_field,
    input  logic [3:0]         scale,
    input  logic signed [31:0] disp,
    input  logic [7:0]         imm,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         code_byte,
    output logic               last
);

    xmse_pkg::q_status_t q_status;
    xmse_pkg::enc_t      push_data;
    xmse_pkg::enc_t      pop_data;
    logic                push;
    logic                pop;

    xmse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .opcode      (opcode),
        .reg_field   (reg_field),
        .rm_field    (rm_field),
        .has_base    (has_base),
        .has_index   (has_index),
        .index_field (index_field),
        .scale       (scale),
        .disp        (disp),
        .imm         (imm),
        .q_status    (q_status),
        .q_push      (push),
        .q_data      (push_data)
    );

    xmse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    xmse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (pop_data),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .code_byte (code_byte),
        .last      (last)
    );

endmodule

### src/xmse_checker.sv
module xmse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] code_byte,
    input logic       last
);

    logic [2:0] run_reg;
    logic       out_xfer;

    assign out_xfer = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else if (out_xfer)
        begin
            run_reg <= last ? 3'd0 : run_reg + 1'b1;
        end
    end

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(code_byte) && $stable(last))
        else $error("stalled output changed");

    a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !last |-> run_reg < 3'd6)
        else $error("instruction longer than seven bytes");

    a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && last |-> run_reg != 3'd0)
        else $error("instruction shorter than two bytes");

endmodule

bind x86_modrm_sib_encoder xmse_checker u_xmse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_byte (code_byte),
    .last      (last)
);
